// File: design/fvml_pkg.sv
// ----------------------------------------------------------------------------
// fvml_pkg
// Shared types and constants of the framed value majority lock.
// ----------------------------------------------------------------------------
package fvml_pkg;

	localparam int BIN_COUNT_DEF = 31;

	localparam logic [1:0] OP_BYTE    = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [7:0] HDR_FIRST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'h55;
	localparam logic [7:0] BIN_MAX    = 8'hFF;
	localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAMES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd2;

	localparam logic [7:0]  RADIUS_LOW_RST = 8'd30;
	localparam logic [15:0] MIN_FRAMES_RST = 16'd8;
	localparam logic [15:0] WINDOW_LEN_RST = 16'd100;

	typedef struct packed {
		logic        done;
		logic [31:0] value;
	} frame_t;

	typedef struct packed {
		logic        locked;
		logic [7:0]  locked_radius;
		logic [15:0] valid_count;
	} res_t;

	typedef struct packed {
		logic busy;
		logic locked;
	} stat_t;

endpackage

// File: design/fvml_item_if.sv
// ----------------------------------------------------------------------------
// fvml_item_if
// Input channel: opcode and received byte with valid/ready.
// ----------------------------------------------------------------------------
interface fvml_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] rx_byte;

	modport source(output valid, opcode, rx_byte, input ready);
	modport sink(input valid, opcode, rx_byte, output ready);
endinterface

// File: design/fvml_result_if.sv
// ----------------------------------------------------------------------------
// fvml_result_if
// Result channel: lock status and frame count with valid/ready.
// ----------------------------------------------------------------------------
interface fvml_result_if;
	logic        valid;
	logic        ready;
	logic        locked;
	logic [7:0]  locked_radius;
	logic [15:0] valid_count;

	modport source(output valid, locked, locked_radius, valid_count, input ready);
	modport sink(input valid, locked, locked_radius, valid_count, output ready);
endinterface

// File: design/fvml_parser.sv
// ----------------------------------------------------------------------------
// fvml_parser
// Header/payload frame parser; flags a completed 32-bit little-endian value.
// ----------------------------------------------------------------------------
module fvml_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_en,
	input  logic            restart,
	input  logic [7:0]      rx_byte,
	output fvml_pkg::frame_t frame
);
	import fvml_pkg::*;

	localparam logic [1:0] PH_HDR1    = 2'd0;
	localparam logic [1:0] PH_HDR2    = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic [1:0]  phase_q;
	logic [1:0]  pos_q;
	logic        done_q;
	logic [7:0]  bytes_q [3];
	logic [31:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR1;
			pos_q   <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (restart) begin
				phase_q <= PH_HDR1;
				pos_q   <= 2'd0;
			end else if (byte_en) begin
				unique case (phase_q)
					PH_HDR1: begin
						if (rx_byte == HDR_FIRST) phase_q <= PH_HDR2;
					end
					PH_HDR2: begin
						if (rx_byte == HDR_SECOND) begin
							pos_q   <= 2'd0;
							phase_q <= PH_PAYLOAD;
						end else if (rx_byte != HDR_FIRST) begin
							phase_q <= PH_HDR1;
						end
					end
					PH_PAYLOAD: begin
						if (pos_q == 2'd3) begin
							pos_q   <= 2'd0;
							phase_q <= PH_HDR1;
							done_q  <= 1'b1;
						end else begin
							pos_q <= pos_q + 2'd1;
						end
					end
					default: phase_q <= PH_HDR1;
				endcase
			end
		end
	end

	// payload holds no reset: it is always written before it is used
	always_ff @(posedge clk) begin
		if (byte_en && !restart && phase_q == PH_PAYLOAD) begin
			if (pos_q == 2'd3) begin
				value_q <= {rx_byte, bytes_q[2], bytes_q[1], bytes_q[0]};
			end else begin
				bytes_q[pos_q] <= rx_byte;
			end
		end
	end

	assign frame.done  = done_q;
	assign frame.value = value_q;

endmodule

// File: design/fvml_hist_mem.sv
// ----------------------------------------------------------------------------
// fvml_hist_mem
// Histogram bin memory with registered read and per-bin valid bits for fast clear.
// ----------------------------------------------------------------------------
module fvml_hist_mem #(
	parameter int BIN_COUNT = fvml_pkg::BIN_COUNT_DEF,
	localparam int IDX_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [7:0]       rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [7:0]       wr_data
);
	import fvml_pkg::*;

	logic [7:0]           mem_q [BIN_COUNT];
	logic [7:0]           rd_s1;
	logic                 rd_vld_s1;
	logic [BIN_COUNT-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	// a bin not written since the last clear reads as zero
	assign rd_data = rd_vld_s1 ? rd_s1 : 8'd0;

endmodule

// File: design/fvml_ctrl.sv
// ----------------------------------------------------------------------------
// fvml_ctrl
// Item sequencer: window counters, bin read-modify-write, fullest-bin scan,
// lock decision and result register.
// ----------------------------------------------------------------------------
module fvml_ctrl #(
	parameter int BIN_COUNT = fvml_pkg::BIN_COUNT_DEF,
	localparam int IDX_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_fire,
	input  logic [1:0]        opcode,
	input  fvml_pkg::frame_t  frame,
	input  logic [7:0]        radius_low,
	input  logic [15:0]       min_frames,
	input  logic [15:0]       window_length,
	output logic              mem_clr,
	output logic              rd_en,
	output logic [IDX_W-1:0]  rd_addr,
	input  logic [7:0]        rd_data,
	output logic              wr_en,
	output logic [IDX_W-1:0]  wr_addr,
	output logic [7:0]        wr_data,
	output fvml_pkg::stat_t   stat,
	output fvml_pkg::res_t    res,
	output logic              res_valid,
	input  logic              res_ready
);
	import fvml_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_RMW    = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_TAIL   = 3'd4;
	localparam logic [2:0] S_DECIDE = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BIN_COUNT - 1);

	logic [2:0]       state_q;
	logic [15:0]      total_q;
	logic [15:0]      tick_q;
	logic             lock_q;
	logic [7:0]       lock_val_q;
	logic [IDX_W-1:0] off_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic [7:0]       best_cnt_q;
	logic [IDX_W-1:0] best_idx_q;
	res_t             res_q;
	logic             res_valid_q;

	logic [31:0]      diff;
	logic             in_range;
	logic [15:0]      tick_n;
	logic [15:0]      total_n;
	logic [17:0]      best_x4;
	logic [17:0]      total_x3;

	assign diff     = frame.value - 32'(radius_low);
	assign in_range = (frame.value >= 32'(radius_low)) && (diff < 32'(BIN_COUNT));
	assign tick_n   = tick_q + 16'd1;
	assign total_n  = (total_q == TOTAL_MAX) ? TOTAL_MAX : total_q + 16'd1;
	assign best_x4  = {8'd0, best_cnt_q, 2'b00};
	assign total_x3 = {2'b00, total_q} + {1'b0, total_q, 1'b0};

	always_comb begin
		mem_clr = 1'b0;
		rd_en   = 1'b0;
		rd_addr = scan_idx_q;
		wr_en   = 1'b0;
		wr_addr = off_q;
		wr_data = (rd_data == BIN_MAX) ? BIN_MAX : rd_data + 8'd1;
		unique case (state_q)
			S_IDLE: begin
				if (item_fire) begin
					if (opcode == OP_RESTART) mem_clr = 1'b1;
					if (opcode == OP_TICK && !lock_q && tick_n >= window_length)
						mem_clr = 1'b1;
				end
			end
			S_CHECK: begin
				if (frame.done && !lock_q && in_range) begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(diff);
				end
			end
			S_RMW:  wr_en = 1'b1;
			S_SCAN: rd_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= 16'd0;
			tick_q      <= 16'd0;
			lock_q      <= 1'b0;
			lock_val_q  <= 8'd0;
			off_q       <= '0;
			scan_idx_q  <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
			best_cnt_q  <= 8'd0;
			best_idx_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == S_SCAN);
			cmp_idx_s1 <= scan_idx_q;
			if (cmp_vld_s1 && rd_data > best_cnt_q) begin
				best_cnt_q <= rd_data;
				best_idx_q <= cmp_idx_s1;
			end
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (item_fire) begin
						state_q <= S_FINISH;
						case (opcode)
							OP_BYTE: state_q <= S_CHECK;
							OP_TICK: begin
								if (!lock_q) begin
									if (tick_n >= window_length) begin
										tick_q  <= 16'd0;
										total_q <= 16'd0;
									end else begin
										tick_q <= tick_n;
									end
								end
							end
							OP_RESTART: begin
								tick_q     <= 16'd0;
								total_q    <= 16'd0;
								lock_q     <= 1'b0;
								lock_val_q <= 8'd0;
							end
							default: ;
						endcase
					end
				end
				S_CHECK: begin
					if (frame.done && !lock_q && in_range) begin
						off_q   <= IDX_W'(diff);
						state_q <= S_RMW;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_RMW: begin
					total_q <= total_n;
					if (total_n >= min_frames) begin
						scan_idx_q <= '0;
						best_cnt_q <= 8'd0;
						best_idx_q <= '0;
						state_q    <= S_SCAN;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_SCAN: begin
					if (scan_idx_q == LAST_IDX) begin
						state_q <= S_TAIL;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				// last bin is compared in this cycle
				S_TAIL: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (best_x4 >= total_x3) begin
						lock_q     <= 1'b1;
						lock_val_q <= radius_low + 8'(best_idx_q);
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					// hold until the result register is free
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && (!res_valid_q || res_ready)) begin
			res_q.locked        <= lock_q;
			res_q.locked_radius <= lock_q ? lock_val_q : 8'd0;
			res_q.valid_count   <= total_q;
		end
	end

	assign res         = res_q;
	assign res_valid   = res_valid_q;
	assign stat.busy   = (state_q != S_IDLE);
	assign stat.locked = lock_q;

endmodule

// File: design/framed_value_majority_lock.sv
// Every item ends in FINISH, which loads the result register once it is free.
// Tick, restart or unused opcode: from IDLE; a byte: via CHECK; a counted in-range frame:
// via CHECK, RMW and, if the bin scan runs, SCAN (one bin read per cycle from the memory port), TAIL, DECIDE.
// A new transaction is accepted the cycle after the result register is loaded.
// Reset (arst_n low): parser, counters, lock and all histogram bins clear at once;
// registers return to radius_low 30, min_frames 8, window_length 100.
// ----------------------------------------------------------------------------
// framed_value_majority_lock
// Frame parser feeding a histogram that locks onto a majority value.
// ----------------------------------------------------------------------------
module framed_value_majority_lock #(
	parameter int BIN_COUNT = fvml_pkg::BIN_COUNT_DEF,
	localparam int IDX_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	fvml_item_if.sink                           item,
	fvml_result_if.source                       result,
	input  logic                                wr_en,
	input  logic [fvml_pkg::CFG_IDX_W-1:0]      reg_idx,
	input  logic [fvml_pkg::CFG_DATA_W-1:0]     wr_data
);
	import fvml_pkg::*;

	logic [7:0]       radius_low_q;
	logic [15:0]      min_frames_q;
	logic [15:0]      window_len_q;
	logic             item_fire;
	frame_t           frame;
	stat_t            stat;
	res_t             res;
	logic             mem_clr;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [7:0]       rd_data;
	logic             bin_wr_en;
	logic [IDX_W-1:0] bin_wr_addr;
	logic [7:0]       bin_wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_low_q <= RADIUS_LOW_RST;
			min_frames_q <= MIN_FRAMES_RST;
			window_len_q <= WINDOW_LEN_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				CFG_RADIUS_LOW: radius_low_q <= wr_data[7:0];
				CFG_MIN_FRAMES: min_frames_q <= wr_data;
				CFG_WINDOW_LEN: window_len_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign item.ready = !stat.busy;
	assign item_fire  = item.valid && item.ready;

	fvml_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (item_fire && item.opcode == OP_BYTE),
		.restart (item_fire && item.opcode == OP_RESTART),
		.rx_byte (item.rx_byte),
		.frame   (frame)
	);

	fvml_hist_mem #(.BIN_COUNT(BIN_COUNT)) u_hist_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (mem_clr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (bin_wr_en),
		.wr_addr (bin_wr_addr),
		.wr_data (bin_wr_data)
	);

	fvml_ctrl #(.BIN_COUNT(BIN_COUNT)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_fire     (item_fire),
		.opcode        (item.opcode),
		.frame         (frame),
		.radius_low    (radius_low_q),
		.min_frames    (min_frames_q),
		.window_length (window_len_q),
		.mem_clr       (mem_clr),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.wr_en         (bin_wr_en),
		.wr_addr       (bin_wr_addr),
		.wr_data       (bin_wr_data),
		.stat          (stat),
		.res           (res),
		.res_valid     (result.valid),
		.res_ready     (result.ready)
	);

	assign result.locked        = res.locked;
	assign result.locked_radius = res.locked_radius;
	assign result.valid_count   = res.valid_count;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire |=> stat.busy)
		else $error("block idle right after accepting a transaction");

	a_unlock_on_restart: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(stat.locked) |-> $past(item_fire && item.opcode == OP_RESTART))
		else $error("lock dropped without a restart");

	a_radius_zero_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.locked) |-> (result.locked_radius == 8'd0))
		else $error("nonzero radius reported while unlocked");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && bin_wr_en))
		else $error("bin read and write in the same cycle");

endmodule

// File: test/framed_value_majority_lock_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_value_majority_lock_tb
// Feeds bytes, ticks and restarts through the item channel and checks every
// status result against a cycle-free model of the parser, histogram and lock.
// Both channels idle and stall at random between register settings.
// ----------------------------------------------------------------------------
module framed_value_majority_lock_tb;
	import fvml_pkg::*;

	localparam int NBINS       = BIN_COUNT_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum logic [1:0] {SEEK_FIRST, SEEK_SECOND, IN_PAYLOAD} parse_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
	} link_event_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  reg_idx;
	logic [CFG_DATA_W-1:0] wr_data;

	fvml_item_if   item_ch();
	fvml_result_if res_ch();

	framed_value_majority_lock dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (res_ch),
		.wr_en   (wr_en),
		.reg_idx (reg_idx),
		.wr_data (wr_data)
	);

	// model state and register copies
	logic [7:0]  c_radius_low;
	logic [15:0] c_min_frames;
	logic [15:0] c_window;
	parse_t      m_phase;
	logic [7:0]  m_payload [4];
	logic [1:0]  m_pos;
	logic [7:0]  m_bins [NBINS];
	logic [15:0] m_frames;
	logic [15:0] m_ticks;
	logic        m_lock;
	logic [7:0]  m_radius;

	link_event_t link_events [$];
	res_t        lock_reports [$];

	int  errors;
	int  events_taken;
	int  reports_checked;
	int  frames_in_range;
	int  locks_taken;
	int  cycles;
	int  send_wait;
	int  take_wait;
	bit  send_gaps;
	bit  take_gaps;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void clear_window();
		for (int i = 0; i < NBINS; i++)
			m_bins[i] = 8'd0;
		m_frames = 16'd0;
		m_ticks  = 16'd0;
	endfunction

	function automatic void clear_tracker();
		m_phase = SEEK_FIRST;
		for (int i = 0; i < 4; i++)
			m_payload[i] = 8'd0;
		m_pos    = 2'd0;
		m_lock   = 1'b0;
		m_radius = 8'd0;
		clear_window();
	endfunction

	function automatic void count_frame(logic [31:0] v);
		int         off;
		int         best_idx;
		logic [7:0] best;
		if (m_lock || v < 32'(c_radius_low) || v > 32'(c_radius_low) + 32'(NBINS - 1))
			return;
		off = int'(v - 32'(c_radius_low));
		frames_in_range++;
		if (m_bins[off] != BIN_MAX)
			m_bins[off] = m_bins[off] + 8'd1;
		if (m_frames != TOTAL_MAX)
			m_frames = m_frames + 16'd1;
		if (m_frames < c_min_frames)
			return;
		best     = 8'd0;
		best_idx = 0;
		for (int i = 0; i < NBINS; i++) begin
			if (m_bins[i] > best) begin
				best     = m_bins[i];
				best_idx = i;
			end
		end
		if (32'(best) * 32'd4 >= 32'(m_frames) * 32'd3) begin
			// radius wraps to 8 bits when the window runs past 255
			m_radius = c_radius_low + 8'(best_idx);
			m_lock   = 1'b1;
			locks_taken++;
		end
	endfunction

	function automatic res_t track_event(logic [1:0] op, logic [7:0] b);
		res_t        r;
		logic [31:0] v;
		if (op == OP_BYTE) begin
			case (m_phase)
				SEEK_FIRST: begin
					if (b == HDR_FIRST)
						m_phase = SEEK_SECOND;
				end
				SEEK_SECOND: begin
					if (b == HDR_SECOND) begin
						m_pos   = 2'd0;
						m_phase = IN_PAYLOAD;
					end else if (b != HDR_FIRST) begin
						m_phase = SEEK_FIRST;
					end
				end
				default: begin
					m_payload[m_pos] = b;
					if (m_pos != 2'd3) begin
						m_pos = m_pos + 2'd1;
					end else begin
						v = {m_payload[3], m_payload[2], m_payload[1], m_payload[0]};
						m_pos   = 2'd0;
						m_phase = SEEK_FIRST;
						count_frame(v);
					end
				end
			endcase
		end else if (op == OP_TICK) begin
			if (!m_lock) begin
				m_ticks = m_ticks + 16'd1;
				if (m_ticks >= c_window)
					clear_window();
			end
		end else if (op == OP_RESTART) begin
			clear_tracker();
		end
		r.locked        = m_lock;
		r.locked_radius = m_lock ? m_radius : 8'd0;
		r.valid_count   = m_frames;
		return r;
	endfunction

	function automatic int draw_wait(bit enabled);
		return enabled ? int'($urandom_range(0, 15)) : 0;
	endfunction

	// driver: hold the transaction until ready, then wait the drawn gap
	always @(posedge clk or negedge arst_n) begin
		link_event_t nxt;
		if (!arst_n) begin
			item_ch.valid   <= 1'b0;
			item_ch.opcode  <= OP_BYTE;
			item_ch.rx_byte <= 8'd0;
			send_wait = 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				lock_reports.push_back(track_event(item_ch.opcode, item_ch.rx_byte));
				events_taken++;
				send_wait = draw_wait(send_gaps);
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (send_wait > 0 || link_events.size() == 0) begin
					if (send_wait > 0)
						send_wait--;
					item_ch.valid <= 1'b0;
				end else begin
					nxt = link_events.pop_front();
					item_ch.valid   <= 1'b1;
					item_ch.opcode  <= nxt.op;
					item_ch.rx_byte <= nxt.data;
				end
			end
		end
	end

	// monitor: compare each result with the oldest expected status
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			take_wait = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (lock_reports.size() == 0) begin
					errors++;
					$display("%0t: unexpected result locked=%0d radius=%0d count=%0d", $time,
						res_ch.locked, res_ch.locked_radius, res_ch.valid_count);
				end else begin
					want = lock_reports.pop_front();
					reports_checked++;
					if (res_ch.locked !== want.locked) begin
						errors++;
						$display("%0t: locked expected %0d actual %0d", $time,
							want.locked, res_ch.locked);
					end
					if (res_ch.locked_radius !== want.locked_radius) begin
						errors++;
						$display("%0t: locked_radius expected %0d actual %0d", $time,
							want.locked_radius, res_ch.locked_radius);
					end
					if (res_ch.valid_count !== want.valid_count) begin
						errors++;
						$display("%0t: valid_count expected %0d actual %0d", $time,
							want.valid_count, res_ch.valid_count);
					end
				end
				take_wait = draw_wait(take_gaps);
			end
			if (take_wait > 0) begin
				take_wait--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				lock_reports.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic void push_event(logic [1:0] op, logic [7:0] b);
		link_event_t e;
		e.op   = op;
		e.data = b;
		link_events.push_back(e);
	endfunction

	function automatic int push_frame(logic [31:0] v, bit repeat_hdr);
		push_event(OP_BYTE, HDR_FIRST);
		if (repeat_hdr)
			push_event(OP_BYTE, HDR_FIRST);
		push_event(OP_BYTE, HDR_SECOND);
		for (int i = 0; i < 4; i++)
			push_event(OP_BYTE, v[8*i +: 8]);
		return repeat_hdr ? 7 : 6;
	endfunction

	function automatic logic [31:0] pick_value(logic [7:0] lo, int fav, int maj_pct);
		logic [31:0] base;
		base = 32'(lo);
		if (int'($urandom_range(0, 99)) < maj_pct)
			return base + 32'(fav);
		case ($urandom_range(0, 5))
			0, 1:    return base + 32'($urandom_range(0, NBINS - 1));
			2:       return ($urandom_range(0, 1) != 0) ? base : base + 32'(NBINS - 1);
			3:       return ($urandom_range(0, 1) != 0) ? base - 32'd1 : base + 32'(NBINS);
			4:       return 32'($urandom_range(0, 255));
			default: return $urandom;
		endcase
	endfunction

	// wait until every queued transaction has been taken and answered
	task automatic settle();
		do
			@(negedge clk);
		while (link_events.size() != 0 || item_ch.valid || lock_reports.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		@(posedge clk);
		wr_en   <= 1'b1;
		reg_idx <= idx;
		wr_data <= data;
		case (idx)
			CFG_RADIUS_LOW: c_radius_low = data[7:0];
			CFG_MIN_FRAMES: c_min_frames = data;
			CFG_WINDOW_LEN: c_window     = data;
			default: ;
		endcase
	endtask

	task automatic configure(logic [7:0] lo, logic [15:0] minf, logic [15:0] win);
		write_reg(CFG_RADIUS_LOW, {8'd0, lo});
		write_reg(CFG_MIN_FRAMES, minf);
		write_reg(CFG_WINDOW_LEN, win);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic run_phase(logic [7:0] lo, logic [15:0] minf, logic [15:0] win, int n);
		int fav;
		int maj_pct;
		int queued;
		int pick;
		configure(lo, minf, win);
		send_gaps = ($urandom_range(0, 3) != 0);
		take_gaps = ($urandom_range(0, 3) != 0);
		fav     = $urandom_range(0, NBINS - 1);
		maj_pct = $urandom_range(40, 95);
		queued  = 0;
		while (queued < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 68) begin
				queued += push_frame(pick_value(lo, fav, maj_pct),
					$urandom_range(0, 4) == 0);
			end else if (pick < 82) begin
				push_event(OP_TICK, 8'($urandom_range(0, 255)));
				queued++;
			end else if (pick < 85) begin
				push_event(OP_RESTART, 8'($urandom_range(0, 255)));
				queued++;
			end else if (pick < 88) begin
				push_event(OP_UNUSED, 8'($urandom_range(0, 255)));
				queued++;
			end else if (pick < 94) begin
				push_event(OP_BYTE, 8'($urandom_range(0, 255)));
				queued++;
			end else begin
				// broken frame: header then junk, or a payload cut by a restart
				push_event(OP_BYTE, HDR_FIRST);
				if ($urandom_range(0, 1) != 0) begin
					push_event(OP_BYTE, 8'($urandom_range(0, 255)));
					queued += 2;
				end else begin
					push_event(OP_BYTE, HDR_SECOND);
					push_event(OP_BYTE, 8'($urandom_range(0, 255)));
					push_event(OP_RESTART, 8'd0);
					queued += 4;
				end
			end
		end
		settle();
	endtask

	initial begin
		int dummy;
		clk             = 1'b0;
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		reg_idx         = CFG_RADIUS_LOW;
		wr_data         = '0;
		item_ch.valid   = 1'b0;
		item_ch.opcode  = OP_BYTE;
		item_ch.rx_byte = 8'd0;
		res_ch.ready    = 1'b0;
		errors          = 0;
		events_taken    = 0;
		reports_checked = 0;
		frames_in_range = 0;
		locks_taken     = 0;
		cycles          = 0;
		send_gaps       = 1'b1;
		take_gaps       = 1'b1;
		c_radius_low    = RADIUS_LOW_RST;
		c_min_frames    = MIN_FRAMES_RST;
		c_window        = WINDOW_LEN_RST;
		clear_tracker();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: unused opcode, tick, restart, byte extremes, repeated
		// header, bad second header byte, out-of-range value, cut payload
		push_event(OP_UNUSED, 8'hFF);
		push_event(OP_TICK, 8'h00);
		push_event(OP_RESTART, 8'hFF);
		push_event(OP_BYTE, 8'h00);
		push_event(OP_BYTE, 8'hFF);
		dummy = push_frame(32'd30, 1'b1);
		push_event(OP_BYTE, HDR_FIRST);
		push_event(OP_BYTE, 8'h12);
		dummy = push_frame(32'hFFFF_FFFF, 1'b0);
		push_event(OP_BYTE, HDR_FIRST);
		push_event(OP_BYTE, HDR_SECOND);
		push_event(OP_BYTE, 8'h01);
		push_event(OP_RESTART, 8'h00);
		settle();

		run_phase(8'd0, 16'd1, 16'd1, 100);
		run_phase(8'd224, 16'hFFFF, 16'hFFFF, 100);
		run_phase(8'd100, 16'd0, 16'd0, 100);
		run_phase(8'd240, 16'd4, 16'd40, 100);

		// lock on one bin, then poke the locked state with frames and a tick
		configure(8'd50, 16'd16, 16'hFFFF);
		push_event(OP_RESTART, 8'd0);
		for (int i = 0; i < 20; i++)
			dummy = push_frame(32'd57, 1'b0);
		dummy = push_frame(32'd60, 1'b0);
		push_event(OP_TICK, 8'd0);
		settle();

		for (int p = 0; p < 5; p++)
			run_phase(8'($urandom_range(0, 224)), 16'($urandom_range(1, 24)),
				16'($urandom_range(4, 300)), 100);

		settle();
		repeat (2 * NBINS + 20) @(posedge clk);
		$display("Ran %0d link events with %0d results checked;", events_taken,
			reports_checked);
		$display("%0d frames fell in range and %0d locks were taken.", frames_in_range,
			locks_taken);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
